>>> rtl/core/priority_slot_allocator_assert.svh
`ifndef PRIORITY_SLOT_ALLOCATOR_ASSERT_SVH
`define PRIORITY_SLOT_ALLOCATOR_ASSERT_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define PSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define PSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/psa_pkg.sv
`timescale 1ns / 1ps

package psa_pkg;

  localparam int SLOTS_DEFAULT = 128;
  localparam int LIFE_W        = 16;
  localparam int LIFE_IN_W     = 15;
  localparam int PRIO_W        = 8;
  localparam int CFG_W         = 8;
  localparam int IDX_OUT_W     = 7;
  localparam int EXP_W         = 8;

  localparam logic [LIFE_W-1:0] FREE_LIFE    = '1;
  localparam logic [PRIO_W-1:0] RESET_PRIO   = 8'd128;
  localparam logic [CFG_W-1:0]  ACTIVE_RESET = 8'd128;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic [LIFE_W-1:0] life;
    logic [PRIO_W-1:0] prio;
    logic              prot;
  } entry_t;

  localparam entry_t FREE_ENTRY = '{life: FREE_LIFE, prio: RESET_PRIO, prot: 1'b0};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_FREE,
    ST_EVICT,
    ST_POST
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic take;
    logic load_retry;
    logic issue;
    logic evict_pass;
    logic tick;
    logic grant;
    logic post;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic none_active;
    logic hit;
    logic sweep_end;
    logic out_busy;
  } status_t;

endpackage

>>> rtl/core/psa_req_if.sv
`timescale 1ns / 1ps

interface psa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [psa_pkg::PRIO_W-1:0]     priority_req;
  logic                           protect_equal;
  logic [psa_pkg::LIFE_IN_W-1:0]  life;

  modport source (output valid, op, priority_req, protect_equal, life, input ready);
  modport sink (input valid, op, priority_req, protect_equal, life, output ready);
endinterface

>>> rtl/core/psa_rsp_if.sv
`timescale 1ns / 1ps

interface psa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            granted;
  logic [psa_pkg::IDX_OUT_W-1:0]   slot_index;
  logic                            evicted;
  logic [psa_pkg::EXP_W-1:0]       expired_count;

  modport source (output valid, granted, slot_index, evicted, expired_count, input ready);
  modport sink (input valid, granted, slot_index, evicted, expired_count, output ready);
endinterface

>>> rtl/core/priority_slot_allocator.sv
`timescale 1ns / 1ps
// Channel  Role      Contents
// req      sink      op, priority_req, protect_equal, life
// rsp      source    granted, slot_index, evicted, expired_count
// cfg      write     active_slots, written through cfg_we and cfg_wdata
//
// A tick sweeps the n active slots, n being the active slot count, through the single
// read port of the slot table, one slot a cycle.
// An allocate makes a free-slot pass, then an eviction pass if no slot is free.
// After reset the table is cleared, one slot a cycle, before requests
// are taken. A result waiting on rsp does not stop the next request being taken,
// but that request's result is held back until the waiting one has gone.

`include "priority_slot_allocator_assert.svh"

module priority_slot_allocator #(
  parameter int SLOTS = psa_pkg::SLOTS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  psa_req_if.sink                   req,
  psa_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [psa_pkg::CFG_W-1:0] cfg_wdata
);

  psa_pkg::cmd_t    cmd;
  psa_pkg::status_t stat;
  logic             req_take;
  logic             rsp_fail;
  logic             fail_clean;
  logic             rsp_expired;

  psa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign req_take    = req.valid && req.ready;
  assign rsp_fail    = rsp.valid && !rsp.granted;
  assign fail_clean  = (rsp.slot_index == '0) && !rsp.evicted;
  assign rsp_expired = rsp.valid && (rsp.expired_count != '0);

  `PSA_ASSERT_NEXT(a_busy_after_take, clk, rst, req_take, !req.ready, "request taken while busy")
  `PSA_ASSERT_NOW(a_fail_fields, clk, rst, rsp_fail, fail_clean, "failed result carries a slot")
  `PSA_ASSERT_NOW(a_tick_no_grant, clk, rst, rsp_expired, !rsp.granted, "tick result shows a grant")
  `PSA_ASSERT_NOW(a_clear_blocks, clk, rst, cmd.clear_wr, !req.ready, "request taken in clear")

endmodule

>>> rtl/core/psa_ram.sv
`timescale 1ns / 1ps

module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/psa_ctrl.sv
`timescale 1ns / 1ps

module psa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_op,
  output logic              req_ready,
  input  psa_pkg::status_t  stat,
  output psa_pkg::cmd_t     cmd
);

  psa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      psa_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_done) begin
          state_next = psa_pkg::ST_IDLE;
        end
      end
      psa_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take = 1'b1;
          if (req_op == psa_pkg::OP_TICK) begin
            state_next = psa_pkg::ST_TICK;
          end else if (stat.none_active) begin
            state_next = psa_pkg::ST_POST;
          end else begin
            state_next = psa_pkg::ST_FREE;
          end
        end
      end
      psa_pkg::ST_TICK: begin
        cmd.issue = 1'b1;
        cmd.tick  = 1'b1;
        if (stat.sweep_end) begin
          state_next = psa_pkg::ST_POST;
        end
      end
      psa_pkg::ST_FREE: begin
        if (stat.hit) begin
          cmd.issue  = 1'b1;
          cmd.grant  = 1'b1;
          state_next = psa_pkg::ST_POST;
        end else if (stat.sweep_end) begin
          cmd.load_retry = 1'b1;
          state_next     = psa_pkg::ST_EVICT;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      psa_pkg::ST_EVICT: begin
        cmd.issue      = 1'b1;
        cmd.evict_pass = 1'b1;
        if (stat.hit) begin
          cmd.grant  = 1'b1;
          state_next = psa_pkg::ST_POST;
        end else if (stat.sweep_end) begin
          state_next = psa_pkg::ST_POST;
        end
      end
      psa_pkg::ST_POST: begin
        if (!stat.out_busy) begin
          cmd.post   = 1'b1;
          state_next = psa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/psa_dp.sv
`timescale 1ns / 1ps

module psa_dp #(
  parameter int SLOTS = psa_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [psa_pkg::CFG_W-1:0]     cfg_wdata,
  psa_req_if.sink                       req,
  psa_rsp_if.source                     rsp,
  input  psa_pkg::cmd_t                 cmd,
  output psa_pkg::status_t              stat
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int N_W   = (CNT_W > psa_pkg::CFG_W) ? CNT_W : psa_pkg::CFG_W;
  localparam int OW    = psa_pkg::IDX_OUT_W;
  localparam int LW    = psa_pkg::LIFE_W;

  logic [psa_pkg::CFG_W-1:0]     active;
  logic [N_W-1:0]                act_wide;
  logic [N_W-1:0]                n_wide;
  logic [CNT_W-1:0]              n;
  logic [CNT_W-1:0]              search_start;
  logic [CNT_W-1:0]              start_eff;
  logic [IDX_W-1:0]              ptr;
  logic [IDX_W-1:0]              ptr_next;
  logic [CNT_W-1:0]              ptr_inc;
  logic [CNT_W-1:0]              left;
  logic                          chk_vld;
  logic [IDX_W-1:0]              chk_addr;
  logic [IDX_W-1:0]              clr_idx;

  logic                          op_r;
  logic [psa_pkg::PRIO_W-1:0]    prio_r;
  logic                          prot_r;
  logic [psa_pkg::LIFE_IN_W-1:0] life_r;

  logic                          granted_r;
  logic                          evicted_r;
  logic [IDX_W-1:0]              idx_r;
  logic [psa_pkg::EXP_W-1:0]     expired;

  logic                          out_vld;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  psa_pkg::entry_t               ram_wdata;
  logic                          ram_re;
  psa_pkg::entry_t               ram_rdata;

  logic                          slot_free;
  logic                          evict_ok;
  logic                          tick_wb;

  psa_ram #(
    .WIDTH ($bits(psa_pkg::entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  assign act_wide  = N_W'(active);
  assign n_wide    = (act_wide > N_W'(SLOTS)) ? N_W'(SLOTS) : act_wide;
  assign n         = CNT_W'(n_wide);
  assign start_eff = (search_start >= n) ? '0 : search_start;
  assign ptr_inc   = CNT_W'(ptr) + CNT_W'(1);
  assign ptr_next  = (ptr_inc >= n) ? '0 : IDX_W'(ptr_inc);
  assign ram_re    = cmd.issue && !cmd.load_retry && (left != '0);

  assign slot_free = (ram_rdata.life == psa_pkg::FREE_LIFE);
  assign evict_ok  = (prio_r <= ram_rdata.prio) &&
                     !((prio_r == ram_rdata.prio) && ram_rdata.prot);
  assign tick_wb   = cmd.tick && chk_vld && !slot_free;

  assign stat.clear_done  = (clr_idx == IDX_W'(SLOTS - 1));
  assign stat.none_active = (n == '0);
  assign stat.hit         = chk_vld && (cmd.evict_pass ? evict_ok : slot_free);
  assign stat.sweep_end   = (left == '0) && !chk_vld;
  assign stat.out_busy    = out_vld && !rsp.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_addr;
    ram_wdata = psa_pkg::FREE_ENTRY;
    if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
    end else if (cmd.grant) begin
      ram_we    = 1'b1;
      ram_wdata = '{life: LW'(life_r), prio: prio_r, prot: prot_r};
    end else if (tick_wb) begin
      ram_we = 1'b1;
      if (ram_rdata.life != '0) begin
        ram_wdata      = ram_rdata;
        ram_wdata.life = ram_rdata.life - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= psa_pkg::ACTIVE_RESET;
      search_start <= '0;
      left         <= '0;
      chk_vld      <= 1'b0;
      clr_idx      <= '0;
      out_vld      <= 1'b0;
    end else begin
      if (cfg_we) begin
        active <= cfg_wdata;
      end
      if (cmd.clear_wr) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (cmd.take) begin
        left    <= n;
        chk_vld <= 1'b0;
        if ((req.op == psa_pkg::OP_ALLOC) && (n != '0)) begin
          search_start <= start_eff;
        end
      end else if (cmd.load_retry) begin
        left    <= n;
        chk_vld <= 1'b0;
      end else if (ram_re) begin
        left    <= left - CNT_W'(1);
        chk_vld <= 1'b1;
      end else begin
        chk_vld <= 1'b0;
      end
      if (cmd.grant) begin
        search_start <= CNT_W'(chk_addr) + CNT_W'(1);
      end
      if (cmd.post) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r      <= req.op;
      prio_r    <= req.priority_req;
      prot_r    <= req.protect_equal;
      life_r    <= req.life;
      granted_r <= 1'b0;
      evicted_r <= 1'b0;
      idx_r     <= '0;
      expired   <= '0;
      ptr       <= (req.op == psa_pkg::OP_TICK) ? '0 : IDX_W'(start_eff);
    end else if (cmd.load_retry) begin
      ptr <= IDX_W'(search_start);
    end else if (ram_re) begin
      ptr <= ptr_next;
    end
    if (ram_re) begin
      chk_addr <= ptr;
    end
    if (cmd.grant) begin
      granted_r <= 1'b1;
      evicted_r <= cmd.evict_pass;
      idx_r     <= chk_addr;
    end
    if (tick_wb && (ram_rdata.life == '0)) begin
      expired <= expired + psa_pkg::EXP_W'(1);
    end
    if (cmd.post) begin
      rsp.granted       <= granted_r;
      rsp.slot_index    <= OW'(idx_r);
      rsp.evicted       <= evicted_r;
      rsp.expired_count <= (op_r == psa_pkg::OP_TICK) ? expired : '0;
    end
  end

  assign rsp.valid = out_vld;

endmodule
